// ----- rtl/core/usn_pkg.sv -----
package usn_pkg;

    localparam int LIMIT_BITS_DEF = 16;
    localparam int TRUNC_LEN      = 12;
    localparam int BURST_BYTES    = 4;

    localparam logic [7:0] CHAR_REPL  = 8'h3f;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_beat;

    // Results of one input beat: up to four explicit bytes, then the
    // optional truncation suffix.
    typedef struct packed {
        logic [BURST_BYTES-1:0][7:0] bytes;
        logic [2:0]                  cnt;
        logic                        trunc;
        logic                        last;
        logic [3:0]                  last_pos;
    } t_burst;

    function automatic logic [7:0] trunc_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h0a;
            4'd1:    c = 8'h5b;
            4'd2:    c = 8'h74;
            4'd3:    c = 8'h72;
            4'd4:    c = 8'h75;
            4'd5:    c = 8'h6e;
            4'd6:    c = 8'h63;
            4'd7:    c = 8'h61;
            4'd8:    c = 8'h74;
            4'd9:    c = 8'h65;
            4'd10:   c = 8'h64;
            4'd11:   c = 8'h5d;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/usn_core.sv -----
module usn_core #(
    parameter int LIMIT_BITS = usn_pkg::LIMIT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [LIMIT_BITS-1:0] i_cfg_wdata,
    input  logic                  i_accept,
    input  usn_pkg::t_in_beat     i_beat,
    output usn_pkg::t_burst       o_desc,
    output logic                  o_desc_nonempty
);

    logic [7:0]            r_held [3];
    logic [1:0]            r_cnt;
    logic [2:0]            r_exp;
    logic [LIMIT_BITS-1:0] r_seen;
    logic                  r_trunc;
    logic [LIMIT_BITS-1:0] r_limit;

    logic [1:0]            n_cnt;
    logic [2:0]            n_exp;
    logic [LIMIT_BITS-1:0] n_seen;
    logic                  n_trunc;

    logic [7:0]            w_b;
    logic                  w_limit_on;
    logic                  w_past;
    logic [LIMIT_BITS:0]   w_seen_inc;
    logic                  w_flush;
    logic                  w_fits;
    logic                  w_complete;
    logic                  w_extend;
    logic [2:0]            w_lead_exp;
    logic [7:0]            w_begin_byte;
    logic                  w_wr_en;
    logic [1:0]            w_wr_idx;
    logic [2:0]            w_nq;
    logic [7:0]            w_spec;
    logic                  w_use_held;
    logic [2:0]            w_cnt_out;
    logic                  w_trunc_out;
    logic [4:0]            w_total;

    assign w_b        = i_beat.in_byte;
    assign w_limit_on = (r_limit != '0);
    assign w_past     = w_limit_on && (r_seen >= r_limit);
    assign w_seen_inc = {1'b0, r_seen} + {{LIMIT_BITS{1'b0}}, 1'b1};
    assign w_flush    = !w_past
                        && ((w_limit_on && (w_seen_inc >= {1'b0, r_limit})) || i_beat.in_last);

    always_comb begin
        w_fits = (w_b[7:6] == 2'b10);
        if (r_cnt == 2'd1) begin
            case (r_held[0])
                8'he0:   w_fits = w_b inside {[8'ha0:8'hbf]};
                8'hed:   w_fits = w_b inside {[8'h80:8'h9f]};
                8'hf0:   w_fits = w_b inside {[8'h90:8'hbf]};
                8'hf4:   w_fits = w_b inside {[8'h80:8'h8f]};
                default: w_fits = (w_b[7:6] == 2'b10);
            endcase
        end
    end

    assign w_complete = (r_cnt != 2'd0) && w_fits && (({1'b0, r_cnt} + 3'd1) >= r_exp);
    assign w_extend   = (r_cnt != 2'd0) && w_fits && !w_complete;

    always_comb begin
        w_lead_exp   = 3'd0;
        w_begin_byte = usn_pkg::CHAR_REPL;
        if (!w_b[7]) begin
            if (w_b < usn_pkg::CHAR_SPACE && w_b != usn_pkg::CHAR_LF
                && w_b != usn_pkg::CHAR_CR && w_b != usn_pkg::CHAR_TAB) begin
                w_begin_byte = usn_pkg::CHAR_SPACE;
            end else begin
                w_begin_byte = w_b;
            end
        end else if (w_b inside {[8'hc2:8'hdf]}) begin
            w_lead_exp = 3'd2;
        end else if (w_b inside {[8'he0:8'hef]}) begin
            w_lead_exp = 3'd3;
        end else if (w_b inside {[8'hf0:8'hf4]}) begin
            w_lead_exp = 3'd4;
        end
    end

    always_comb begin
        w_nq       = 3'd0;
        w_spec     = usn_pkg::CHAR_REPL;
        w_use_held = 1'b0;
        w_cnt_out  = 3'd0;
        n_cnt      = 2'd0;
        n_exp      = 3'd0;
        n_seen     = r_seen;
        n_trunc    = r_trunc;
        w_wr_en    = 1'b0;
        w_wr_idx   = 2'd0;
        if (w_past) begin
            w_cnt_out = {1'b0, r_cnt};
            w_nq      = {1'b0, r_cnt};
            n_trunc   = 1'b1;
        end else begin
            if (w_limit_on) begin
                n_seen = w_seen_inc[LIMIT_BITS-1:0];
            end
            if (w_complete) begin
                w_use_held = 1'b1;
                w_cnt_out  = {1'b0, r_cnt} + 3'd1;
            end else if (w_extend) begin
                w_wr_en  = 1'b1;
                w_wr_idx = r_cnt;
                n_cnt    = r_cnt + 2'd1;
                n_exp    = r_exp;
                if (w_flush) begin
                    w_cnt_out = {1'b0, r_cnt} + 3'd1;
                    w_nq      = w_cnt_out;
                end
            end else if (w_lead_exp == 3'd0) begin
                w_cnt_out = {1'b0, r_cnt} + 3'd1;
                w_nq      = {1'b0, r_cnt};
                w_spec    = w_begin_byte;
            end else begin
                w_wr_en = 1'b1;
                n_cnt   = 2'd1;
                n_exp   = w_lead_exp;
                if (w_flush) begin
                    w_cnt_out = {1'b0, r_cnt} + 3'd1;
                    w_nq      = w_cnt_out;
                end else begin
                    w_cnt_out = {1'b0, r_cnt};
                    w_nq      = w_cnt_out;
                end
            end
            if (w_flush) begin
                n_cnt = 2'd0;
                n_exp = 3'd0;
            end
        end
        if (i_beat.in_last) begin
            n_cnt   = 2'd0;
            n_exp   = 3'd0;
            n_seen  = '0;
            n_trunc = 1'b0;
        end
    end

    assign w_trunc_out = i_beat.in_last && (r_trunc || w_past);
    assign w_total     = {2'b00, w_cnt_out}
                         + (w_trunc_out ? 5'(usn_pkg::TRUNC_LEN) : 5'd0);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (w_use_held) begin
                o_desc.bytes[i] = (2'(i) < r_cnt) ? r_held[i] : w_b;
            end else begin
                o_desc.bytes[i] = (3'(i) < w_nq) ? usn_pkg::CHAR_REPL : w_spec;
            end
        end
        o_desc.bytes[3] = w_use_held ? w_b : w_spec;
        o_desc.cnt      = w_cnt_out;
        o_desc.trunc    = w_trunc_out;
        o_desc.last     = i_beat.in_last;
        o_desc.last_pos = 4'(w_total - 5'd1);
    end

    assign o_desc_nonempty = (w_cnt_out != 3'd0) || w_trunc_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= 2'd0;
            r_exp   <= 3'd0;
            r_seen  <= '0;
            r_trunc <= 1'b0;
            r_limit <= '0;
        end else begin
            if (i_accept) begin
                r_cnt   <= n_cnt;
                r_exp   <= n_exp;
                r_seen  <= n_seen;
                r_trunc <= n_trunc;
            end
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && w_wr_en) begin
            r_held[w_wr_idx] <= w_b;
        end
    end

    a_held_shorter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd0) |-> ((r_exp >= 3'd2) && ({1'b0, r_cnt} < r_exp)))
        else $error("held sequence is not shorter than its announced length");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_beat.in_last) |=> ((r_cnt == 2'd0) && !r_trunc && (r_seen == '0)))
        else $error("string state not cleared after its final beat");

endmodule

// ----- rtl/core/usn_burst.sv -----
module usn_burst (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  usn_pkg::t_burst   i_desc,
    output logic              o_free,
    output logic              o_valid,
    output usn_pkg::t_out_beat o_data,
    input  logic              i_stall
);

    usn_pkg::t_burst    r_desc;
    logic               r_busy;
    logic [3:0]         r_pos;
    usn_pkg::t_out_beat r_out;
    logic               r_ovalid;

    logic               w_out_ready;
    logic               w_move;
    logic               w_done;
    logic [3:0]         w_tidx;
    logic [7:0]         w_byte;

    assign w_out_ready = !r_ovalid || !i_stall;
    assign w_move      = r_busy && w_out_ready;
    assign w_done      = w_move && (r_pos == r_desc.last_pos);
    assign o_free      = !r_busy || w_done;

    assign w_tidx = r_pos - {1'b0, r_desc.cnt};
    assign w_byte = ({1'b0, r_desc.cnt} > r_pos) ? r_desc.bytes[r_pos[1:0]]
                                                 : usn_pkg::trunc_char(w_tidx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pos    <= 4'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_load) begin
                r_busy <= 1'b1;
                r_pos  <= 4'd0;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end else if (w_move) begin
                r_pos <= r_pos + 4'd1;
            end
            if (w_move) begin
                r_ovalid <= 1'b1;
            end else if (w_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_desc <= i_desc;
        end
        if (w_move) begin
            r_out.out_byte <= w_byte;
            r_out.out_last <= w_done && r_desc.last;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    a_pos_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pos <= r_desc.last_pos))
        else $error("burst position ran past its final byte");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_busy || w_done))
        else $error("new burst loaded over one still in flight");

    a_desc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> ((i_desc.cnt <= 3'd4) && ((i_desc.cnt != 3'd0) || i_desc.trunc)))
        else $error("burst loaded with a bad byte count");

endmodule

// ----- rtl/core/utf8_stream_sanitizer.sv -----
// Strict UTF-8 sanitizer for a byte stream.
// Input channel: i_in_valid / o_in_stall carry one text byte per beat with a
// flag on the final byte of a string. Output channel: o_out_valid /
// i_out_stall carry the cleaned bytes; the final byte of a string has
// out_last set. i_cfg_we writes the byte limit (zero means no limit).
// A beat may give no output bytes (a multi-byte sequence still being held)
// or a burst of up to 16: held bytes when a sequence completes, '?' bytes
// for a broken or cut sequence, and the truncation suffix at string end.
// An accepted beat's burst is loaded into the burst register, and its bytes
// then pass through the output register. The output side moves one byte
// per cycle unless the receiver stalls; a new input beat is taken in every
// cycle in which the burst register is empty or hands over its last byte,
// so unstalled plain text runs at one byte per cycle.
// When the receiver stalls, the output register holds its byte, the burst
// register fills behind it, and then o_in_stall rises.
// Reset clears the sequence state, the counters, the limit and the busy
// and valid flags of both output-side registers, but not their data.
module utf8_stream_sanitizer #(
    parameter int LIMIT_BITS = usn_pkg::LIMIT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [LIMIT_BITS-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    input  usn_pkg::t_in_beat     i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output usn_pkg::t_out_beat    o_out_data,
    input  logic                  i_out_stall
);

    usn_pkg::t_burst w_desc;
    logic            w_desc_nonempty;
    logic            w_free;
    logic            w_accept;

    assign o_in_stall = !w_free;
    assign w_accept   = i_in_valid && w_free;

    usn_core #(
        .LIMIT_BITS(LIMIT_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_accept        (w_accept),
        .i_beat          (i_in_data),
        .o_desc          (w_desc),
        .o_desc_nonempty (w_desc_nonempty)
    );

    usn_burst u_burst (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept && w_desc_nonempty),
        .i_desc  (w_desc),
        .o_free  (w_free),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule
